// ===== hdl/sslf_pkg.sv =====
package sslf_pkg;

    localparam int DEF_SERVO_COUNT  = 3;
    localparam int DEF_PRESET_COUNT = 10;

    localparam int CFG_IDX_W = 8;

    localparam logic [7:0]  MAX_ANGLE        = 8'd180;
    localparam logic [7:0]  RESET_ANGLE      = 8'd90;
    localparam logic [15:0] RESET_BLINK_MS   = 16'd500;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INTERVAL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_ANGLE     = 8'd1;

    typedef enum logic [3:0] {
        FN_TICK   = 4'd0,
        FN_SERVO  = 4'd1,
        FN_RGB    = 4'd2,
        FN_OFF    = 4'd3,
        FN_FADE   = 4'd4,
        FN_BLINK  = 4'd5,
        FN_PRESET = 4'd6,
        FN_HOME   = 4'd7,
        FN_STATUS = 4'd8
    } t_func;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_UNKNOWN_SERVO  = 2'd1,
        ST_UNKNOWN_PRESET = 2'd2,
        ST_UNKNOWN_CMD    = 2'd3
    } t_status;

    typedef struct packed {
        t_func       func;
        logic [2:0]  servo_index;
        logic [7:0]  angle;
        logic [7:0]  new_red;
        logic [7:0]  new_green;
        logic [7:0]  new_blue;
        logic [3:0]  preset_index;
        logic [31:0] now_ms;
    } t_cmd_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] left_eye_pos;
        logic [7:0] right_eye_pos;
        logic [7:0] jaw_pos;
        logic [7:0] drive_red;
        logic [7:0] drive_green;
        logic [7:0] drive_blue;
        logic [7:0] level_red;
        logic [7:0] level_green;
        logic [7:0] level_blue;
    } t_result_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [15:0]          wdata;
    } t_cfg_write;

    // Preset colors as {red, green, blue}; unlisted slots are black.
    function automatic logic [23:0] preset_color(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = {8'd255, 8'd0,   8'd0};
            4'd1:    rgb = {8'd0,   8'd255, 8'd0};
            4'd2:    rgb = {8'd0,   8'd0,   8'd255};
            4'd3:    rgb = {8'd255, 8'd255, 8'd255};
            4'd4:    rgb = {8'd255, 8'd255, 8'd0};
            4'd5:    rgb = {8'd0,   8'd255, 8'd255};
            4'd6:    rgb = {8'd255, 8'd0,   8'd255};
            4'd7:    rgb = {8'd255, 8'd165, 8'd0};
            4'd8:    rgb = {8'd255, 8'd192, 8'd203};
            4'd9:    rgb = {8'd128, 8'd0,   8'd128};
            default: rgb = 24'd0;
        endcase
        return rgb;
    endfunction

    function automatic logic [7:0] sat_angle(input logic [7:0] a);
        return (a > MAX_ANGLE) ? MAX_ANGLE : a;
    endfunction

endpackage

// ===== hdl/sslf_chan_if.sv =====
interface sslf_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/servo_slew_and_led_fade_controller.sv =====
// Channel  Dir  Payload                Transaction when
// i_cmd    in   sslf_pkg::t_cmd_item     i_cmd.valid && i_cmd.ready
// o_res    out  sslf_pkg::t_result_item  o_res.valid && o_res.ready
// i_cfg    in   sslf_pkg::t_cfg_write    i_cfg.valid (ready held high)
//
// One command or tick per cycle while o_res is not stalled.
// Input register feeds one pass of servo, fade and blink logic into the result register.
// State updates as the item moves from the input register to the result register.
// A stalled result holds both registers; i_cmd.ready drops only while both are full.
// Reset (synchronous, i_rst_n low) restores servos to 90 degrees and clears LED state.
module servo_slew_and_led_fade_controller #(
    parameter int SERVO_COUNT  = sslf_pkg::DEF_SERVO_COUNT,
    parameter int PRESET_COUNT = sslf_pkg::DEF_PRESET_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sslf_chan_if.sink   i_cmd,
    sslf_chan_if.source o_res,
    sslf_chan_if.sink   i_cfg
);

    logic                 r_s1_valid;
    sslf_pkg::t_cmd_item  r_s1;
    logic                 r_out_valid;
    sslf_pkg::t_result_item r_out;
    logic                 s1_advance;

    logic [15:0] r_blink_interval;
    logic [7:0]  r_home_angle;

    logic [7:0]  r_servo_pos  [SERVO_COUNT];
    logic [7:0]  r_servo_goal [SERVO_COUNT];
    logic [7:0]  r_level      [3];
    logic [7:0]  r_fade_goal  [3];
    logic [7:0]  r_drive      [3];
    logic        r_fade_active;
    logic        r_blink_active;
    logic        r_blink_lit;
    logic [31:0] r_blink_last;

    logic [7:0]  n_servo_pos  [SERVO_COUNT];
    logic [7:0]  n_servo_goal [SERVO_COUNT];
    logic [7:0]  n_level      [3];
    logic [7:0]  n_fade_goal  [3];
    logic [7:0]  n_drive      [3];
    logic        n_fade_active;
    logic        n_blink_active;
    logic        n_blink_lit;
    logic [31:0] n_blink_last;
    sslf_pkg::t_status n_status;
    logic [7:0]  pos_out [3];

    function automatic logic [7:0] servo_step(input logic [7:0] pos, input logic [7:0] goal);
        logic signed [8:0] d;
        logic signed [8:0] h;
        d = $signed({1'b0, goal}) - $signed({1'b0, pos});
        h = (d + $signed({8'b0, d[8]})) >>> 1;
        if (d > -9'sd2 && d < 9'sd2) begin
            return goal;
        end
        return pos + h[7:0];
    endfunction

    function automatic logic [7:0] fade_step(input logic [7:0] lvl, input logic [7:0] goal);
        logic signed [8:0] d;
        logic signed [8:0] q;
        d = $signed({1'b0, goal}) - $signed({1'b0, lvl});
        q = (d + $signed({7'b0, {2{d[8]}}})) >>> 2;
        return lvl + q[7:0];
    endfunction

    function automatic logic fade_close(input logic [7:0] lvl, input logic [7:0] goal);
        logic signed [8:0] e;
        e = $signed({1'b0, lvl}) - $signed({1'b0, goal});
        return (e > -9'sd3 && e < 9'sd3);
    endfunction

    assign s1_advance  = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_s1_valid || s1_advance;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_comb begin
        logic [7:0]  fade_lvl [3];
        logic        fade_near;
        logic [23:0] preset_rgb;
        logic        blink_due;

        n_servo_pos    = r_servo_pos;
        n_servo_goal   = r_servo_goal;
        n_level        = r_level;
        n_fade_goal    = r_fade_goal;
        n_drive        = r_drive;
        n_fade_active  = r_fade_active;
        n_blink_active = r_blink_active;
        n_blink_lit    = r_blink_lit;
        n_blink_last   = r_blink_last;
        n_status       = sslf_pkg::ST_OK;
        fade_near      = 1'b1;
        preset_rgb     = sslf_pkg::preset_color(r_s1.preset_index);
        blink_due      = (r_s1.now_ms - r_blink_last) > {16'b0, r_blink_interval};
        for (int c = 0; c < 3; c++) begin
            fade_lvl[c] = fade_step(r_level[c], r_fade_goal[c]);
        end

        case (r_s1.func)
            sslf_pkg::FN_TICK: begin
                for (int i = 0; i < SERVO_COUNT; i++) begin
                    n_servo_pos[i] = servo_step(r_servo_pos[i], r_servo_goal[i]);
                end
                if (r_fade_active) begin
                    for (int c = 0; c < 3; c++) begin
                        if (!fade_close(fade_lvl[c], r_fade_goal[c])) begin
                            fade_near = 1'b0;
                        end
                    end
                    if (fade_near) begin
                        n_level = r_fade_goal;
                    end else begin
                        n_level = fade_lvl;
                    end
                    n_fade_active = !fade_near;
                    n_drive       = n_level;
                end
                if (r_blink_active && blink_due) begin
                    n_blink_last = r_s1.now_ms;
                    n_blink_lit  = !r_blink_lit;
                    // toggling to lit shows the level, to dark shows black
                    if (r_blink_lit) begin
                        n_drive = '{default: '0};
                    end else begin
                        n_drive = n_level;
                    end
                end
            end
            sslf_pkg::FN_SERVO: begin
                if ({1'b0, r_s1.servo_index} < 4'(SERVO_COUNT)) begin
                    for (int i = 0; i < SERVO_COUNT; i++) begin
                        if (r_s1.servo_index == 3'(i)) begin
                            n_servo_goal[i] = sslf_pkg::sat_angle(r_s1.angle);
                        end
                    end
                end else begin
                    n_status = sslf_pkg::ST_UNKNOWN_SERVO;
                end
            end
            sslf_pkg::FN_RGB: begin
                n_fade_active  = 1'b0;
                n_blink_active = 1'b0;
                n_level        = '{r_s1.new_red, r_s1.new_green, r_s1.new_blue};
                n_drive        = n_level;
            end
            sslf_pkg::FN_OFF: begin
                n_fade_active  = 1'b0;
                n_blink_active = 1'b0;
                n_level        = '{default: '0};
                n_drive        = '{default: '0};
            end
            sslf_pkg::FN_FADE: begin
                n_fade_active  = 1'b1;
                n_blink_active = 1'b0;
                n_fade_goal    = '{r_s1.new_red, r_s1.new_green, r_s1.new_blue};
            end
            sslf_pkg::FN_BLINK: begin
                n_blink_active = 1'b1;
                n_fade_active  = 1'b0;
                n_blink_last   = r_s1.now_ms;
                n_blink_lit    = 1'b0;
            end
            sslf_pkg::FN_PRESET: begin
                if ({1'b0, r_s1.preset_index} < 5'(PRESET_COUNT)) begin
                    n_fade_active  = 1'b0;
                    n_blink_active = 1'b0;
                    n_level        = '{preset_rgb[23:16], preset_rgb[15:8], preset_rgb[7:0]};
                    n_drive        = n_level;
                end else begin
                    n_status = sslf_pkg::ST_UNKNOWN_PRESET;
                end
            end
            sslf_pkg::FN_HOME: begin
                for (int i = 0; i < SERVO_COUNT; i++) begin
                    n_servo_goal[i] = sslf_pkg::sat_angle(r_home_angle);
                end
            end
            sslf_pkg::FN_STATUS: begin
            end
            default: begin
                n_status = sslf_pkg::ST_UNKNOWN_CMD;
            end
        endcase
    end

    // absent servos report zero
    for (genvar k = 0; k < 3; k++) begin : g_pos
        if (k < SERVO_COUNT) begin : g_present
            assign pos_out[k] = n_servo_pos[k];
        end else begin : g_absent
            assign pos_out[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_s1 <= i_cmd.payload;
        end
        if (s1_advance) begin
            r_out.status        <= n_status;
            r_out.left_eye_pos  <= pos_out[0];
            r_out.right_eye_pos <= pos_out[1];
            r_out.jaw_pos       <= pos_out[2];
            r_out.drive_red     <= n_drive[0];
            r_out.drive_green   <= n_drive[1];
            r_out.drive_blue    <= n_drive[2];
            r_out.level_red     <= n_level[0];
            r_out.level_green   <= n_level[1];
            r_out.level_blue    <= n_level[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_interval <= sslf_pkg::RESET_BLINK_MS;
            r_home_angle     <= sslf_pkg::RESET_ANGLE;
        end else if (i_cfg.valid) begin
            if (i_cfg.payload.reg_index == sslf_pkg::CFG_BLINK_INTERVAL) begin
                r_blink_interval <= i_cfg.payload.wdata;
            end else if (i_cfg.payload.reg_index == sslf_pkg::CFG_HOME_ANGLE) begin
                r_home_angle <= i_cfg.payload.wdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servo_pos    <= '{default: sslf_pkg::RESET_ANGLE};
            r_servo_goal   <= '{default: sslf_pkg::RESET_ANGLE};
            r_level        <= '{default: '0};
            r_fade_goal    <= '{default: '0};
            r_drive        <= '{default: '0};
            r_fade_active  <= 1'b0;
            r_blink_active <= 1'b0;
            r_blink_lit    <= 1'b0;
            r_blink_last   <= '0;
        end else if (s1_advance) begin
            r_servo_pos    <= n_servo_pos;
            r_servo_goal   <= n_servo_goal;
            r_level        <= n_level;
            r_fade_goal    <= n_fade_goal;
            r_drive        <= n_drive;
            r_fade_active  <= n_fade_active;
            r_blink_active <= n_blink_active;
            r_blink_lit    <= n_blink_lit;
            r_blink_last   <= n_blink_last;
        end
    end

    a_fade_blink_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fade_active && r_blink_active))
        else $error("fade and blink active together");

    a_unknown_cmd_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance && (r_s1.func > sslf_pkg::FN_STATUS)
        |=> o_res.payload.status == sslf_pkg::ST_UNKNOWN_CMD)
        else $error("unknown command not reported");

    a_servo_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.payload.left_eye_pos <= sslf_pkg::MAX_ANGLE
                      && o_res.payload.right_eye_pos <= sslf_pkg::MAX_ANGLE
                      && o_res.payload.jaw_pos <= sslf_pkg::MAX_ANGLE))
        else $error("servo position beyond limit");

endmodule
